// ----- rtl/core/u2u8_pkg.sv -----
// ============================================================================
// u2u8_pkg: shared types and helpers for the code unit to UTF-8 transcoder
// Holds the beat structs, the queue entry layout and the UTF-8 encoder.
// ============================================================================
package u2u8_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_BYTES = 1'b1;

    // Unit mode codes
    localparam logic MODE_UTF16 = 1'b0;
    localparam logic MODE_UTF32 = 1'b1;

    localparam logic [15:0] SURR_HI_FIRST = 16'hD800;
    localparam logic [15:0] SURR_HI_LAST  = 16'hDBFF;
    localparam logic [15:0] SURR_LO_FIRST = 16'hDC00;
    localparam logic [15:0] SURR_LO_LAST  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;
    localparam logic [31:0] MAX_CODEPOINT = 32'h0010FFFF;

    localparam logic [7:0] FFFD_B0   = 8'hEF;
    localparam logic [7:0] FFFD_B1   = 8'hBF;
    localparam logic [7:0] FFFD_B2   = 8'hBD;
    localparam logic [7:0] LEAD2     = 8'hC0;
    localparam logic [7:0] LEAD3     = 8'hE0;
    localparam logic [7:0] LEAD4     = 8'hF0;
    localparam logic [7:0] CONT_MARK = 8'h80;

    // Queue between the front and back parts
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam int unsigned MAX_BYTES = 6;
    localparam int unsigned BIDX_W    = $clog2(MAX_BYTES);

    typedef struct packed {
        logic [31:0] code_unit;
        logic        last_unit;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_beat_t;

    // Encoding of one code point: up to four bytes
    typedef struct packed {
        logic [3:0][7:0]   bytes;
        logic [2:0]        cnt;
    } seq_t;

    // Byte run for one accepted item
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [BIDX_W-1:0]         cnt;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic seq_t encode_cp(logic [31:0] cp);
        seq_t s;
        s.bytes = '0;
        s.cnt   = 3'd0;
        if (cp <= 32'h7F) begin
            s.bytes[0] = cp[7:0];
            s.cnt      = 3'd1;
        end else if (cp <= 32'h7FF) begin
            s.bytes[0] = LEAD2 | {3'b000, cp[10:6]};
            s.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
            s.cnt      = 3'd2;
        end else if (cp <= 32'hFFFF) begin
            s.bytes[0] = LEAD3 | {4'b0000, cp[15:12]};
            s.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
            s.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
            s.cnt      = 3'd3;
        end else if (cp <= MAX_CODEPOINT) begin
            s.bytes[0] = LEAD4 | {5'b00000, cp[20:18]};
            s.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
            s.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
            s.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
            s.cnt      = 3'd4;
        end else begin
            s.bytes[0] = FFFD_B0;
            s.bytes[1] = FFFD_B1;
            s.bytes[2] = FFFD_B2;
            s.cnt      = 3'd3;
        end
        return s;
    endfunction

endpackage

// ----- rtl/core/u2u8_front.sv -----
// ============================================================================
// u2u8_front: unit intake and classification
// Holds the mode registers and the pending high surrogate, and turns each
// accepted unit into a complete byte run for the queue; a unit that only
// holds a high surrogate produces no run.
module u2u8_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  u2u8_pkg::in_beat_t              in_data,
    input  logic                            cfg_wr_en,
    input  logic [u2u8_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic                            cfg_data,
    input  u2u8_pkg::q_stat_t               q_stat,
    output logic                            q_push,
    output u2u8_pkg::entry_t                q_wdata
);

    logic        mode_reg, mode_next;
    logic        swap_reg, swap_next;
    logic        pend_reg, pend_next;
    logic [9:0]  payload_reg, payload_next;

    logic              accept;
    logic [31:0]       u32;
    logic [15:0]       u16;
    logic              is_hi;
    logic              is_lo;
    logic              prefix;
    u2u8_pkg::seq_t    main_seq;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        u32 = swap_reg ? {in_data.code_unit[7:0], in_data.code_unit[15:8],
                          in_data.code_unit[23:16], in_data.code_unit[31:24]}
                       : in_data.code_unit;
        u16 = swap_reg ? {in_data.code_unit[7:0], in_data.code_unit[15:8]}
                       : in_data.code_unit[15:0];
        is_hi = (u16 >= u2u8_pkg::SURR_HI_FIRST) && (u16 <= u2u8_pkg::SURR_HI_LAST);
        is_lo = (u16 >= u2u8_pkg::SURR_LO_FIRST) && (u16 <= u2u8_pkg::SURR_LO_LAST);

        prefix       = 1'b0;
        pend_next    = pend_reg;
        payload_next = payload_reg;
        main_seq     = '0;

        if (mode_reg == u2u8_pkg::MODE_UTF32) begin
            // A surrogate held across a mode change is dropped silently.
            main_seq  = u2u8_pkg::encode_cp(u32);
            pend_next = 1'b0;
        end else if (pend_reg && is_lo) begin
            main_seq  = u2u8_pkg::encode_cp({11'd0,
                            u2u8_pkg::SUPP_BASE + {1'b0, payload_reg, u16[9:0]}});
            pend_next = 1'b0;
        end else begin
            prefix    = pend_reg;
            pend_next = 1'b0;
            if (is_hi) begin
                if (in_data.last_unit) begin
                    main_seq = u2u8_pkg::encode_cp(32'h0000FFFD);
                end else begin
                    pend_next    = 1'b1;
                    payload_next = u16[9:0];
                end
            end else if (is_lo) begin
                main_seq = u2u8_pkg::encode_cp(32'h0000FFFD);
            end else begin
                main_seq = u2u8_pkg::encode_cp({16'd0, u16});
            end
        end

        q_wdata = '0;
        if (prefix) begin
            q_wdata.bytes[0] = u2u8_pkg::FFFD_B0;
            q_wdata.bytes[1] = u2u8_pkg::FFFD_B1;
            q_wdata.bytes[2] = u2u8_pkg::FFFD_B2;
            q_wdata.bytes[3] = main_seq.bytes[0];
            q_wdata.bytes[4] = main_seq.bytes[1];
            q_wdata.bytes[5] = main_seq.bytes[2];
            q_wdata.cnt      = 3'd3 + main_seq.cnt;
        end else begin
            q_wdata.bytes[0] = main_seq.bytes[0];
            q_wdata.bytes[1] = main_seq.bytes[1];
            q_wdata.bytes[2] = main_seq.bytes[2];
            q_wdata.bytes[3] = main_seq.bytes[3];
            q_wdata.cnt      = main_seq.cnt;
        end
    end

    // Items that only hold a pending high surrogate produce no run and skip the queue.
    assign q_push = accept && (q_wdata.cnt != 3'd0);

    always_comb
    begin
        mode_next = mode_reg;
        swap_next = swap_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                u2u8_pkg::CFG_UNIT_MODE:  mode_next = cfg_data;
                u2u8_pkg::CFG_SWAP_BYTES: swap_next = cfg_data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= u2u8_pkg::MODE_UTF16;
            swap_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            payload_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            swap_reg <= swap_next;
            if (accept)
            begin
                pend_reg    <= pend_next;
                payload_reg <= payload_next;
            end
        end
    end

endmodule

// ----- rtl/core/u2u8_queue.sv -----
// ============================================================================
// u2u8_queue: short run queue
// Two-entry FIFO of byte runs between the front and the back part.
// ============================================================================
module u2u8_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  u2u8_pkg::entry_t   wdata,
    input  logic               pop,
    output u2u8_pkg::entry_t   rdata,
    output u2u8_pkg::q_stat_t  stat
);

    u2u8_pkg::entry_t                  slot_reg [u2u8_pkg::QDEPTH];
    logic [u2u8_pkg::QPTR_W-1:0]       wptr_reg, wptr_next;
    logic [u2u8_pkg::QPTR_W-1:0]       rptr_reg, rptr_next;
    logic [u2u8_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == u2u8_pkg::QCNT_W'(u2u8_pkg::QDEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign rdata      = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = pop  ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ----- rtl/core/u2u8_back.sv -----
// ============================================================================
// u2u8_back: byte serializer
// Takes byte runs from the queue and sends them one byte per beat through a
// registered output, marking the final byte of each run.
// ============================================================================
module u2u8_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  u2u8_pkg::q_stat_t     q_stat,
    input  u2u8_pkg::entry_t      q_rdata,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output u2u8_pkg::out_beat_t   out_data
);

    u2u8_pkg::entry_t               cur_reg, cur_next;
    logic [u2u8_pkg::BIDX_W-1:0]    idx_reg, idx_next;
    logic                           busy_reg, busy_next;
    logic                           ov_reg, ov_next;
    u2u8_pkg::out_beat_t            od_reg, od_next;

    logic emit;
    logic at_last;
    logic need;

    always_comb
    begin
        emit    = busy_reg && (!ov_reg || out_ready);
        at_last = (idx_reg == cur_reg.cnt - 1'b1);
        // The next run is fetched as the last byte of this one goes out.
        need    = !busy_reg || (emit && at_last);
        q_pop   = need && !q_stat.empty;

        cur_next  = q_pop ? q_rdata : cur_reg;
        busy_next = q_pop ? 1'b1 : ((emit && at_last) ? 1'b0 : busy_reg);
        idx_next  = q_pop ? '0 : (emit ? idx_reg + 1'b1 : idx_reg);

        ov_next = emit ? 1'b1 : (out_ready ? 1'b0 : ov_reg);
        od_next = od_reg;
        if (emit)
        begin
            od_next.out_byte = cur_reg.bytes[idx_reg];
            od_next.run_last = at_last;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        od_reg  <= od_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule

// ----- rtl/core/unicode_to_utf8_transcoder.sv -----
// ============================================================================
// unicode_to_utf8_transcoder: UTF-16 / UTF-32 code units to UTF-8 bytes
// The first byte of an accepted unit passes through the run queue, the back
// part's current-run register and its output register before it is valid.
// The output sends one byte per cycle while out_ready is high, and a unit
// expands to between zero and six bytes; input beats are taken every cycle
// while the two-entry run queue has room.
// Reset clears the queue, the output stage, any held surrogate and both mode
// registers (UTF-16 units, no byte swap).
// ============================================================================
module unicode_to_utf8_transcoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  u2u8_pkg::in_beat_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output u2u8_pkg::out_beat_t             out_data,
    input  logic                            cfg_wr_en,
    input  logic [u2u8_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic                            cfg_data
);

    u2u8_pkg::q_stat_t  q_stat;
    u2u8_pkg::entry_t   q_wdata;
    u2u8_pkg::entry_t   q_rdata;
    logic               q_push;
    logic               q_pop;

    u2u8_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    u2u8_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    u2u8_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- rtl/core/u2u8_checker.sv -----
// ============================================================================
// u2u8_checker: port-level checks for the transcoder
// Watches the output beats for well-formed UTF-8 run structure.
// ============================================================================
module u2u8_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  u2u8_pkg::out_beat_t             out_data
);

    // A stalled output beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // Only a multi-byte run has bytes before its last one, and those are never ASCII.
    a_mid_not_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.run_last |-> out_data.out_byte[7])
        else $error("ASCII byte inside a run");

    // A lead byte is always followed by continuation bytes of the same run.
    a_lead_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.out_byte[7:6] == 2'b11) |-> !out_data.run_last)
        else $error("lead byte closes a run");

    // Overlong or out-of-range lead bytes never appear.
    a_lead_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.out_byte != 8'hC0) && (out_data.out_byte != 8'hC1)
                      && (out_data.out_byte < 8'hF5))
        else $error("invalid UTF-8 lead byte");

endmodule

bind unicode_to_utf8_transcoder u2u8_checker u_chk (.*);
